// ----- rtl/hss_pkg.sv -----
package hss_pkg;

  // Widths of the timing registers, of the scanline counter and of the configuration port
  localparam int unsigned PorchW   = 8;
  localparam int unsigned VisibleW = 11;
  localparam int unsigned LineW    = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Blank-line ACR packets go out only on lines that are a multiple of this (power of two)
  localparam int unsigned AcrPeriod    = 4;
  localparam int unsigned AcrPeriodLog = $clog2(AcrPeriod);

  // Scanline counter value after reset (two lines preloaded)
  localparam logic [LineW-1:0] LineCountReset = LineW'(2);

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_DVI_ONLY    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRONT_PORCH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SYNC        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BACK_PORCH  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_VISIBLE     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TOTAL       = 3'd5;

  typedef enum logic [3:0] {
    KIND_BLANK        = 4'd0,
    KIND_VSYNC        = 4'd1,
    KIND_DVI_ACTIVE   = 4'd2,
    KIND_PIXELS       = 4'd3,
    KIND_ACR_VS_ON    = 4'd4,
    KIND_INFO_VS_ON   = 4'd5,
    KIND_ACR          = 4'd6,
    KIND_AVI          = 4'd7,
    KIND_BLANK_DI     = 4'd8,
    KIND_BLANK_NULL   = 4'd9,
    KIND_ACTIVE_DI    = 4'd10,
    KIND_ACTIVE_NULL  = 4'd11
  } line_kind_e;

  typedef struct packed {
    logic                dvi_only;
    logic [PorchW-1:0]   front_porch_lines;
    logic [PorchW-1:0]   sync_lines;
    logic [PorchW-1:0]   back_porch_lines;
    logic [VisibleW-1:0] visible_lines;
    logic [LineW-1:0]    total_lines;
  } cfg_t;

  typedef struct packed {
    line_kind_e          line_kind;
    logic                frame_start;
    logic                audio_tick;
    logic                pixel_request;
    logic [LineW-1:0]    current_line;
    logic [VisibleW-1:0] active_row;
    logic                buffer_select;
  } res_t;

  // Decision for one event: the result and the next scheduler state
  typedef struct packed {
    res_t             res;
    logic             hdr_posted;
    logic             ping_pong;
    logic [LineW-1:0] line_count;
  } dec_t;

endpackage

// ----- rtl/hss_line_decode.sv -----
module hss_line_decode (
  input  hss_pkg::cfg_t              cfg_i,
  input  logic [hss_pkg::LineW-1:0]  line_i,
  input  logic                       hdr_posted_i,
  input  logic                       ping_pong_i,
  input  logic                       audio_ready_i,
  output hss_pkg::dec_t              dec_o
);
  import hss_pkg::*;

  logic [PorchW:0]     sync_end;
  logic [PorchW+1:0]   bp_end;
  logic [LineW-1:0]    act_start;
  logic                in_front, in_vsync, in_back, in_active;
  logic                first_vsync, acr_line;
  logic [LineW-1:0]    row_diff;
  logic [LineW:0]      line_inc;
  logic                hdmi;
  line_kind_e          kind;

  assign sync_end  = {1'b0, cfg_i.front_porch_lines} + {1'b0, cfg_i.sync_lines};
  assign bp_end    = {1'b0, sync_end} + {2'b00, cfg_i.back_porch_lines};
  assign act_start = (cfg_i.total_lines > {1'b0, cfg_i.visible_lines})
                   ? cfg_i.total_lines - {1'b0, cfg_i.visible_lines}
                   : '0;

  assign in_front    = line_i < {{(LineW-PorchW){1'b0}}, cfg_i.front_porch_lines};
  assign in_vsync    = !in_front && (line_i < {{(LineW-PorchW-1){1'b0}}, sync_end});
  assign in_back     = (line_i >= {{(LineW-PorchW-1){1'b0}}, sync_end})
                    && (line_i < {{(LineW-PorchW-2){1'b0}}, bp_end});
  assign in_active   = !in_front && !in_vsync && !in_back;
  assign first_vsync = line_i == {{(LineW-PorchW){1'b0}}, cfg_i.front_porch_lines};
  assign acr_line    = (line_i >= {{(LineW-PorchW-1){1'b0}}, sync_end})
                    && (line_i < act_start)
                    && (line_i[AcrPeriodLog-1:0] == '0);
  assign row_diff    = line_i - act_start;
  assign line_inc    = {1'b0, line_i} + (LineW+1)'(1);
  assign hdmi        = !cfg_i.dvi_only;

  always_comb begin
    if (in_vsync) begin
      if (!hdmi) kind = KIND_VSYNC;
      else if (first_vsync) kind = KIND_ACR_VS_ON;
      else kind = KIND_INFO_VS_ON;
    end else if (in_active && !hdr_posted_i) begin
      if (!hdmi) kind = KIND_DVI_ACTIVE;
      else if (audio_ready_i) kind = KIND_ACTIVE_DI;
      else kind = KIND_ACTIVE_NULL;
    end else if (in_active) begin
      kind = KIND_PIXELS;
    end else begin
      if (!hdmi) kind = KIND_BLANK;
      else if (acr_line) kind = KIND_ACR;
      else if (line_i == '0) kind = KIND_AVI;
      else if (audio_ready_i) kind = KIND_BLANK_DI;
      else kind = KIND_BLANK_NULL;
    end
  end

  always_comb begin
    dec_o.res.line_kind     = kind;
    dec_o.res.frame_start   = in_vsync && first_vsync;
    dec_o.res.audio_tick    = hdmi && !hdr_posted_i;
    dec_o.res.pixel_request = in_active && !hdr_posted_i;
    dec_o.res.current_line  = line_i;
    dec_o.res.active_row    = (in_active && (line_i >= act_start))
                            ? row_diff[VisibleW-1:0] : '0;
    dec_o.res.buffer_select = ping_pong_i;
    dec_o.hdr_posted        = in_active && !hdr_posted_i;
    dec_o.ping_pong         = !ping_pong_i;
    // Hold the counter while the header half of an active line is out
    if (in_active && !hdr_posted_i) begin
      dec_o.line_count = line_i;
    end else if (line_inc >= {1'b0, cfg_i.total_lines}) begin
      dec_o.line_count = '0;
    end else begin
      dec_o.line_count = line_inc[LineW-1:0];
    end
  end

endmodule

// ----- rtl/hss_out_stage.sv -----
module hss_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  hss_pkg::res_t res_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          take_i,
  output hss_pkg::res_t res_o
);
  import hss_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Room for a new result when empty or when the held one leaves now
  assign ready_o = !valid_q || take_i;
  assign valid_d = load_i ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/hdmi_scanline_scheduler_unit.sv -----
// Channel   | Group  | tdata (low bit up)                          | tuser
// ----------+--------+---------------------------------------------+------------------
// events in | s_axis | [0] audio_ready, [7:1] zero                  | none
// lines out | m_axis | [0] frame_start [1] audio_tick               | [3:0] line_kind
//           |        | [2] pixel_request [14:3] current_line        |
//           |        | [25:15] active_row [26] buffer_select, zero up|
// config    | cfg_*  | write enable, 3-bit register index, 12-bit data, no read-back
//
// One event is taken per cycle unless stalled; its decision is ready in the result
// register on the next cycle. The scheduler state (line counter, header flag, ping-pong
// bit) updates at acceptance, so back-to-back events see each other's effects with no
// bubble. The result register is the only buffer: s_axis_tready is low only while a
// result is held and m_axis_tready is low. Reset loads the timing defaults and line 2.
module hdmi_scanline_scheduler_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // event stream: [0] audio_ready
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  // line decisions: [0] frame_start [1] audio_tick [2] pixel_request
  // [14:3] current_line [25:15] active_row [26] buffer_select
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,
  // [3:0] line_kind
  output logic [3:0]                    m_axis_tuser,
  // register writes
  input  logic                          cfg_we_i,
  input  logic [hss_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hss_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import hss_pkg::*;

  cfg_t             cfg_q;
  logic [LineW-1:0] line_q;
  logic             hdr_posted_q;
  logic             ping_pong_q;
  logic             in_acc;
  logic             out_ready;
  dec_t             dec;
  res_t             res_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dvi_only          <= 1'b0;
      cfg_q.front_porch_lines <= PorchW'(10);
      cfg_q.sync_lines        <= PorchW'(2);
      cfg_q.back_porch_lines  <= PorchW'(33);
      cfg_q.visible_lines     <= VisibleW'(480);
      cfg_q.total_lines       <= LineW'(525);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DVI_ONLY:    cfg_q.dvi_only          <= cfg_wdata_i[0];
        CFG_FRONT_PORCH: cfg_q.front_porch_lines <= cfg_wdata_i[PorchW-1:0];
        CFG_SYNC:        cfg_q.sync_lines        <= cfg_wdata_i[PorchW-1:0];
        CFG_BACK_PORCH:  cfg_q.back_porch_lines  <= cfg_wdata_i[PorchW-1:0];
        CFG_VISIBLE:     cfg_q.visible_lines     <= cfg_wdata_i[VisibleW-1:0];
        CFG_TOTAL:       cfg_q.total_lines       <= cfg_wdata_i[LineW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = out_ready;
  assign in_acc        = s_axis_tvalid && out_ready;

  hss_line_decode u_decode (
    .cfg_i         (cfg_q),
    .line_i        (line_q),
    .hdr_posted_i  (hdr_posted_q),
    .ping_pong_i   (ping_pong_q),
    .audio_ready_i (s_axis_tdata[0]),
    .dec_o         (dec)
  );

  // Advance the scheduler state on each accepted event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q       <= LineCountReset;
      hdr_posted_q <= 1'b0;
      ping_pong_q  <= 1'b0;
    end else if (in_acc) begin
      line_q       <= dec.line_count;
      hdr_posted_q <= dec.hdr_posted;
      ping_pong_q  <= dec.ping_pong;
    end
  end

  hss_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_acc),
    .res_i   (dec.res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tuser = res_out.line_kind;
  assign m_axis_tdata = {5'b0,
                         res_out.buffer_select,
                         res_out.active_row,
                         res_out.current_line,
                         res_out.pixel_request,
                         res_out.audio_tick,
                         res_out.frame_start};

  // The header flag never stays set across two events
  a_hdr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && hdr_posted_q) |=> !hdr_posted_q)
    else $error("header flag held over two events");

  // The counter holds while an active line's header is outstanding
  a_line_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && dec.hdr_posted) |=> (line_q == $past(line_q)))
    else $error("line counter moved on a header event");

  // Ping-pong flips on every accepted event
  a_pp_flips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (ping_pong_q != $past(ping_pong_q)))
    else $error("buffer select did not alternate");

  // A pixel request only comes with an active-line header kind
  a_preq_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_out.pixel_request) |->
      (res_out.line_kind == KIND_DVI_ACTIVE || res_out.line_kind == KIND_ACTIVE_DI
       || res_out.line_kind == KIND_ACTIVE_NULL))
    else $error("pixel request on a non-header line");

endmodule

// ----- tb/hdmi_scanline_scheduler_unit_checker.sv -----
`timescale 1ns / 1ps

module hdmi_scanline_scheduler_unit_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         event_valid_i,
  input  logic                         event_ready_i,
  input  logic [7:0]                   event_data_i,  // [0] audio_ready, [7:1] zero
  input  logic                         line_valid_i,
  input  logic                         line_ready_i,
  // [0] frame_start [1] audio_tick [2] pixel_request [14:3] current_line
  // [25:15] active_row [26] buffer_select, zero up
  input  logic [31:0]                  line_data_i,
  input  logic [3:0]                   line_user_i,   // [3:0] line_kind
  input  logic                         cfg_we_i,
  input  logic [hss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hss_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import hss_pkg::*;

  // Shadow copy of the timing registers
  logic                dvi_only_q;
  logic [PorchW-1:0]   front_q;
  logic [PorchW-1:0]   sync_q;
  logic [PorchW-1:0]   back_q;
  logic [VisibleW-1:0] visible_q;
  logic [LineW-1:0]    total_q;

  // Shadow copy of the scheduler state
  logic [LineW-1:0]    line_q;
  logic                header_q;
  logic                ping_q;

  res_t                expected_lines[$];
  int unsigned         fails;

  function automatic res_t schedule_line(input logic audio);
    int unsigned cur, sync_start, sync_end, bp_end, act_start, tot, vis, nxt;
    logic in_vsync, in_front, in_back, in_active, acr_due, hdmi;
    res_t r;
    cur        = line_q;
    tot        = total_q;
    vis        = visible_q;
    sync_start = front_q;
    sync_end   = sync_start + sync_q;
    bp_end     = sync_end + back_q;
    act_start  = (tot > vis) ? tot - vis : 0;
    in_vsync   = (cur >= sync_start) && (cur < sync_end);
    in_front   = cur < sync_start;
    in_back    = (cur >= sync_end) && (cur < bp_end);
    in_active  = !in_vsync && !in_front && !in_back;
    acr_due    = (cur >= sync_end) && (cur < act_start) && ((cur % AcrPeriod) == 0);
    hdmi       = !dvi_only_q;

    r = '0;
    r.current_line  = line_q;
    r.buffer_select = ping_q;
    r.audio_tick    = hdmi && !header_q;
    // rows below the active start stay at zero
    if (in_active && cur >= act_start) r.active_row = VisibleW'(cur - act_start);
    ping_q = !ping_q;

    if (in_vsync) begin
      header_q      = 1'b0;
      r.frame_start = (cur == sync_start);
      if (!hdmi) r.line_kind = KIND_VSYNC;
      else r.line_kind = (cur == sync_start) ? KIND_ACR_VS_ON : KIND_INFO_VS_ON;
    end else if (in_active && !header_q) begin
      r.pixel_request = 1'b1;
      if (!hdmi) r.line_kind = KIND_DVI_ACTIVE;
      else r.line_kind = audio ? KIND_ACTIVE_DI : KIND_ACTIVE_NULL;
      header_q = 1'b1;
    end else if (in_active) begin
      r.line_kind = KIND_PIXELS;
      header_q    = 1'b0;
    end else begin
      // a header left over from a register change is dropped here
      header_q = 1'b0;
      if (!hdmi) r.line_kind = KIND_BLANK;
      else if (acr_due) r.line_kind = KIND_ACR;
      else if (cur == 0) r.line_kind = KIND_AVI;
      else r.line_kind = audio ? KIND_BLANK_DI : KIND_BLANK_NULL;
    end

    // advance only once the whole line is done; wrap at or beyond the total
    if (!header_q) begin
      nxt    = cur + 1;
      line_q = (nxt >= tot) ? '0 : LineW'(nxt);
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
    if (want_v != got_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : check
    res_t want;
    if (!rst_ni) begin
      dvi_only_q = 1'b0;
      front_q    = PorchW'(10);
      sync_q     = PorchW'(2);
      back_q     = PorchW'(33);
      visible_q  = VisibleW'(480);
      total_q    = LineW'(525);
      line_q     = LineCountReset;
      header_q   = 1'b0;
      ping_q     = 1'b0;
      expected_lines.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DVI_ONLY:    dvi_only_q = cfg_wdata_i[0];
          CFG_FRONT_PORCH: front_q    = cfg_wdata_i[PorchW-1:0];
          CFG_SYNC:        sync_q     = cfg_wdata_i[PorchW-1:0];
          CFG_BACK_PORCH:  back_q     = cfg_wdata_i[PorchW-1:0];
          CFG_VISIBLE:     visible_q  = cfg_wdata_i[VisibleW-1:0];
          CFG_TOTAL:       total_q    = cfg_wdata_i[LineW-1:0];
          default: ;
        endcase
      end
      if (event_valid_i && event_ready_i) begin
        expected_lines.push_back(schedule_line(event_data_i[0]));
      end
      if (line_valid_i && line_ready_i) begin
        if (expected_lines.size() == 0) begin
          fails++;
          $display("%0t: unexpected line result, expected none, actual kind %0d data %h",
                   $time, line_user_i, line_data_i);
        end else begin
          want = expected_lines.pop_front();
          compare_field("line_kind", want.line_kind, line_user_i);
          compare_field("frame_start", want.frame_start, line_data_i[0]);
          compare_field("audio_tick", want.audio_tick, line_data_i[1]);
          compare_field("pixel_request", want.pixel_request, line_data_i[2]);
          compare_field("current_line", want.current_line, line_data_i[14:3]);
          compare_field("active_row", want.active_row, line_data_i[25:15]);
          compare_field("buffer_select", want.buffer_select, line_data_i[26]);
        end
      end
      fail_count_o <= fails;
      pending_o    <= expected_lines.size();
    end
  end

endmodule

// ----- tb/hdmi_scanline_scheduler_unit_test.sv -----
`timescale 1ns / 1ps

module hdmi_scanline_scheduler_unit_test;
  import hss_pkg::*;

  // Generous bound on the whole run, slowest legal handshakes included
  localparam int unsigned CycleLimit = 200000;

  logic                clk_i     = 1'b0;
  logic                rst_n     = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata   = '0;     // [0] audio_ready, [7:1] zero
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [31:0]         m_tdata;            // frame_start, audio_tick, pixel_request, ...
  logic [3:0]          m_tuser;            // [3:0] line_kind
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles       = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  hdmi_scanline_scheduler_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  hdmi_scanline_scheduler_unit_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .event_valid_i (s_tvalid),
    .event_ready_i (s_tready),
    .event_data_i  (s_tdata),
    .line_valid_i  (m_tvalid),
    .line_ready_i  (m_tready),
    .line_data_i   (m_tdata),
    .line_user_i   (m_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #6 clk_i = ~clk_i;

  // Stall the line consumer at the current idle rate
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Write all six timing registers, one per cycle; the block must be idle
  task automatic load_timing(input logic dvi, input int unsigned front, input int unsigned sync_len,
                             input int unsigned back, input int unsigned visible,
                             input int unsigned total);
    logic [CfgIdxW-1:0]  regs [6];
    logic [CfgDataW-1:0] vals [6];
    regs = '{CFG_DVI_ONLY, CFG_FRONT_PORCH, CFG_SYNC, CFG_BACK_PORCH, CFG_VISIBLE, CFG_TOTAL};
    vals = '{CfgDataW'(dvi), CfgDataW'(front), CfgDataW'(sync_len), CfgDataW'(back),
             CfgDataW'(visible), CfgDataW'(total)};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one line-slot-done request, with random gaps before it; return once accepted
  task automatic push_event(input logic audio);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, audio};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // Send a run of requests with random audio, then drain every pending line result
  task automatic run_events(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) push_event(1'($urandom_range(0, 1)));
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned front, sync_len, back, visible, total;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Sender mostly busy, receiver mostly stalled
    send_idle_pct = 10;
    recv_idle_pct = 81;

    // Reset timing: front porch blank lines from the preloaded line 2
    run_events(2);
    // Compact HDMI frame from line 4: ACR, active headers and pixels, AVI on line 0,
    // both vsync kinds with frame start; stop with a header still posted
    load_timing(1'b0, 1, 2, 2, 3, 8);
    run_events(13);
    // DVI, longer back porch: drop the posted header, active line below the start
    load_timing(1'b1, 1, 2, 4, 1, 9);
    run_events(8);
    // Visible above total, total of one, counter already beyond the total
    load_timing(1'b0, 0, 1, 0, 2047, 1);
    run_events(5);

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 10;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        2: load_timing(1'($urandom_range(0, 1)), 255, 255, 255, 2047, 2816);
        5: load_timing(1'($urandom_range(0, 1)), 0, 1, 0, 1, 2);
        7: load_timing(1'($urandom_range(0, 1)), 0, 0, 0, 0, 0);
        8: load_timing(1'($urandom_range(0, 1)), 255, 255, 255, 2047, 4095);
        default: begin
          // short frames so the counter wraps many times
          front    = $urandom_range(0, 6);
          sync_len = $urandom_range(1, 4);
          back     = $urandom_range(0, 9);
          visible  = $urandom_range(1, 12);
          total    = front + sync_len + back + visible + $urandom_range(0, 4) - 2;
          if ($urandom_range(0, 3) == 0) total = $urandom_range(0, 40);
          load_timing(1'($urandom_range(0, 1)), front, sync_len, back, visible, total);
        end
      endcase
      run_events($urandom_range(45, 75));
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hss_pkg.sv
rtl/hss_line_decode.sv
rtl/hss_out_stage.sv
rtl/hdmi_scanline_scheduler_unit.sv
tb/hdmi_scanline_scheduler_unit_checker.sv
tb/hdmi_scanline_scheduler_unit_test.sv
